// ----- sv/itp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

   // operator stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // token codes
   localparam logic [3:0] OP_OPEN   = 4'd0;
   localparam logic [3:0] OP_CLOSE  = 4'd1;
   localparam logic [3:0] OP_NEG    = 4'd2;
   localparam logic [3:0] OP_POW    = 4'd3;
   localparam logic [3:0] OP_MUL    = 4'd4;
   localparam logic [3:0] OP_DIV    = 4'd5;
   localparam logic [3:0] OP_MOD    = 4'd6;
   localparam logic [3:0] OP_ADD    = 4'd7;
   localparam logic [3:0] OP_SUB    = 4'd8;
   localparam logic [3:0] OP_END    = 4'd9;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CLOSE = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [3:0] push_op;
   } stack_ctrl_type;

   typedef struct packed {
      logic              is_number;
      logic signed [31:0] value;
      logic [3:0]        op;
      logic [1:0]        error;
   } result_type;

   // priority of an operator sitting on the stack (smaller binds tighter)
   function automatic logic [3:0] in_stack_pri(input logic [3:0] op);
      logic [3:0] pri;
      case (op)
         OP_OPEN:  pri = 4'd8;
         OP_CLOSE: pri = 4'd0;
         OP_NEG:   pri = 4'd2;
         OP_POW:   pri = 4'd3;
         OP_MUL:   pri = 4'd4;
         OP_DIV:   pri = 4'd4;
         OP_MOD:   pri = 4'd4;
         OP_ADD:   pri = 4'd5;
         OP_SUB:   pri = 4'd5;
         default:  pri = 4'd9;
      endcase
      return pri;
   endfunction

   // priority of an arriving operator
   function automatic logic [3:0] incoming_pri(input logic [3:0] op);
      logic [3:0] pri;
      case (op)
         OP_OPEN:  pri = 4'd0;
         OP_CLOSE: pri = 4'd0;
         OP_NEG:   pri = 4'd1;
         OP_POW:   pri = 4'd3;
         OP_MUL:   pri = 4'd4;
         OP_DIV:   pri = 4'd4;
         OP_MOD:   pri = 4'd4;
         OP_ADD:   pri = 4'd5;
         OP_SUB:   pri = 4'd5;
         default:  pri = 4'd8;
      endcase
      return pri;
   endfunction

endpackage

`default_nettype wire

// ----- sv/itp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// infix token channel
interface itp_req_if;
   logic              valid;
   logic              ready;
   logic              is_number;
   logic signed [31:0] number_value;
   logic [3:0]        op_code;

   modport source (output valid, output is_number, output number_value, output op_code,
                   input ready);
   modport sink   (input valid, input is_number, input number_value, input op_code,
                   output ready);
endinterface

// postfix token channel
interface itp_rsp_if;
   logic              valid;
   logic              ready;
   logic              out_is_number;
   logic signed [31:0] out_value;
   logic [3:0]        out_op;
   logic              last;
   logic [1:0]        error;

   modport source (output valid, output out_is_number, output out_value, output out_op,
                   output last, output error, input ready);
   modport sink   (input valid, input out_is_number, input out_value, input out_op,
                   input last, input error, output ready);
endinterface

`default_nettype wire

// ----- sv/itp_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itp_stack (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire itp_pkg::stack_ctrl_type ctrl,
   output logic [3:0]                  top_op,
   output logic [itp_pkg::CNT_W-1:0]   count
);

   logic [3:0]                stack_mem [itp_pkg::STACK_DEPTH];
   logic [itp_pkg::CNT_W-1:0] count_ff;
   logic [itp_pkg::CNT_W-1:0] count_in;
   logic [3:0]                top_ff;
   logic [itp_pkg::CNT_W-1:0] below_pos;

   // entry under the top becomes the new top on a pop
   assign below_pos = count_ff - itp_pkg::CNT_W'(2);
   assign top_op    = top_ff;
   assign count     = count_ff;

   // fill count update
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + itp_pkg::CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - itp_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entry write at the fill count, registered copy of the top entry
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         stack_mem[count_ff[itp_pkg::IDX_W-1:0]] <= ctrl.push_op;
         top_ff                                  <= ctrl.push_op;
      end else if (ctrl.pop) begin
         top_ff <= stack_mem[below_pos[itp_pkg::IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

// ----- sv/infix_to_postfix_converter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sequence: a beat is taken in an idle cycle, then the sequencer runs its stack steps (a pop,
//   the push or the final emit), then releases the held last result
// flow: a new token is taken only in idle, after the previous one is through; the final step
//   emits a result for a number, end, stray close or overflow; output stalls hold the
//   sequencer
// reset: synchronous, active high; clears the sequencer, the fill count and the valids

module infix_to_postfix_converter_top (
   input wire logic    clock,
   input wire logic    reset,
   itp_req_if.sink     req_bus,
   itp_rsp_if.source   rsp_bus
);

   itp_pkg::state_type       state_ff, state_in;
   logic                     isnum_ff;
   logic signed [31:0]       value_ff;
   logic [3:0]               op_ff;
   logic                     hold_valid_ff, hold_valid_in;
   itp_pkg::result_type      hold_ff, hold_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_last_ff, rsp_last_in;
   itp_pkg::result_type      rsp_ff, rsp_in;

   itp_pkg::stack_ctrl_type  stack_ctrl;
   logic [3:0]               top_op;
   logic [itp_pkg::CNT_W-1:0] stack_count;

   logic                     out_free;
   logic                     step;
   logic                     new_valid;
   itp_pkg::result_type      new_res;
   logic                     done;
   logic                     can_pop;
   logic                     full;

   itp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctrl  (stack_ctrl),
      .top_op(top_op),
      .count (stack_count)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign step     = (state_ff == itp_pkg::ST_RUN) && out_free;
   assign full     = stack_count >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
   assign can_pop  = (stack_count != '0) && (top_op <= itp_pkg::OP_SUB) &&
                     (itp_pkg::in_stack_pri(top_op) <= itp_pkg::incoming_pri(op_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itp_pkg::ST_IDLE: begin
            if (req_bus.valid) state_in = itp_pkg::ST_RUN;
         end
         itp_pkg::ST_RUN: begin
            if (step && done) state_in = itp_pkg::ST_LAST;
         end
         itp_pkg::ST_LAST: begin
            if (out_free) state_in = itp_pkg::ST_IDLE;
         end
         default: state_in = itp_pkg::ST_IDLE;
      endcase
   end

   // one stack step per cycle while the output is free: pop/emit, push, or final token
   always_comb begin
      new_valid  = 1'b0;
      new_res    = '0;
      done       = 1'b0;
      stack_ctrl = '0;
      if (step) begin
         if (isnum_ff) begin
            new_valid         = 1'b1;
            new_res.is_number = 1'b1;
            new_res.value     = value_ff;
            done              = 1'b1;
         end else if (op_ff > itp_pkg::OP_END) begin
            done = 1'b1;
         end else if (op_ff == itp_pkg::OP_CLOSE) begin
            if (stack_count == '0) begin
               new_valid     = 1'b1;
               new_res.op    = itp_pkg::OP_CLOSE;
               new_res.error = itp_pkg::ERR_CLOSE;
               done          = 1'b1;
            end else begin
               stack_ctrl.pop = 1'b1;
               if (top_op == itp_pkg::OP_OPEN) begin
                  done = 1'b1;
               end else begin
                  new_valid  = 1'b1;
                  new_res.op = top_op;
               end
            end
         end else if (op_ff == itp_pkg::OP_END) begin
            new_valid = 1'b1;
            if (stack_count != '0) begin
               stack_ctrl.pop = 1'b1;
               new_res.op     = top_op;
            end else begin
               new_res.op = itp_pkg::OP_END;
               done       = 1'b1;
            end
         end else if (can_pop) begin
            stack_ctrl.pop = 1'b1;
            new_valid      = 1'b1;
            new_res.op     = top_op;
         end else if (full) begin
            new_valid     = 1'b1;
            new_res.op    = op_ff;
            new_res.error = itp_pkg::ERR_FULL;
            done          = 1'b1;
         end else begin
            stack_ctrl.push    = 1'b1;
            stack_ctrl.push_op = op_ff;
            done               = 1'b1;
         end
      end
   end

   // hold stage keeps the newest result until we know whether it is the last one
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      if (new_valid) begin
         hold_valid_in = 1'b1;
         hold_in       = new_res;
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
            rsp_last_in  = 1'b0;
         end
      end else if ((state_ff == itp_pkg::ST_LAST) && out_free && hold_valid_ff) begin
         hold_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_ff;
         rsp_last_in   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itp_pkg::ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      if (req_bus.valid && req_bus.ready) begin
         isnum_ff <= req_bus.is_number;
         value_ff <= req_bus.number_value;
         op_ff    <= req_bus.op_code;
      end
   end

   // channel outputs
   assign req_bus.ready         = (state_ff == itp_pkg::ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_is_number = rsp_ff.is_number;
   assign rsp_bus.out_value     = rsp_ff.value;
   assign rsp_bus.out_op        = rsp_ff.op;
   assign rsp_bus.error         = rsp_ff.error;
   assign rsp_bus.last          = rsp_last_ff;

endmodule

`default_nettype wire
